// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertion helpers with synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define WBPS_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("wbps assertion failed");

// condition at one edge implies expression at the next
`define WBPS_ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("wbps assertion failed");

`endif

// ===== rtl/core/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// shared constants and types of the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int REG_BYTES   = 16;
    localparam int PAT_CAP     = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;

    localparam int DATA_W      = 8;
    localparam int ADDR_W      = 47;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int WIN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int MASK_W      = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2,
        REG_WILDCARD_MASK  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [LEN_W-1:0]                 eff_len;
        logic [REG_BYTES-1:0][DATA_W-1:0] pat;
        logic [MASK_W-1:0]                wild;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [ADDR_W-1:0] addr;
        logic              first;
    } t_in_word;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
    } t_match;

endpackage

// ===== rtl/core/wbps_in_if.sv =====
// ----------------------------------------------------------------------------
// wbps_in_if
// input byte channel: valid/ready with byte, address and region flag
// ----------------------------------------------------------------------------
interface wbps_in_if;
    logic                       valid;
    logic                       ready;
    logic [wbps_pkg::DATA_W-1:0] data_byte;
    logic [wbps_pkg::ADDR_W-1:0] byte_address;
    logic                       region_first;

    modport source (output valid, output data_byte, output byte_address,
                    output region_first, input ready);
    modport sink   (input valid, input data_byte, input byte_address,
                    input region_first, output ready);
endinterface

// ===== rtl/core/wbps_out_if.sv =====
// ----------------------------------------------------------------------------
// wbps_out_if
// result channel: valid/ready with match start address
// ----------------------------------------------------------------------------
interface wbps_out_if;
    logic                       valid;
    logic                       ready;
    logic [wbps_pkg::ADDR_W-1:0] match_address;

    modport source (output valid, output match_address, input ready);
    modport sink   (input valid, input match_address, output ready);
endinterface

// ===== rtl/core/wildcard_byte_pattern_scanner_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_core
// a taken byte word sits in the input register; its match address goes out of the result register
// throughput: one byte word per cycle while the result side is not stalled, held by the combinational window compare
// a stalled result register holds the input register; both fill back to back
// reset (synchronous, active low) empties both registers, window and count,
// and sets pattern length 1 with all pattern bytes and wildcards zero
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wildcard_byte_pattern_scanner_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    wbps_in_if.sink                         i_in,
    wbps_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // input register stage
    logic                        r_in_valid;
    wbps_pkg::t_in_word          r_in;

    // result register stage
    logic                        r_out_valid;
    logic [wbps_pkg::ADDR_W-1:0] r_out_addr;

    wbps_pkg::t_cfg              w_cfg;
    wbps_pkg::t_match            w_res;
    logic                        w_adv;
    logic                        w_proc;

    // the result register frees up when empty or when its word is taken
    assign w_adv      = !r_out_valid || o_out.ready;
    // the held word goes through the compare when the result side can move
    assign w_proc     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    wbps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    wbps_matcher u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_proc),
        .i_word  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // capture a new byte word whenever the input register has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.data  <= i_in.data_byte;
            r_in.addr  <= i_in.byte_address;
            r_in.first <= i_in.region_first;
        end
    end

    // a word without a match leaves the result register empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.hit) begin
            r_out_addr <= w_res.addr;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.match_address = r_out_addr;

    // a stalled word in the input register is never dropped
    `WBPS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid)
    // the compare reports a hit only for a word that actually moves on
    `WBPS_ASSERT(a_hit_gated, i_clk, i_rst_n, w_proc || !w_res.hit)
    // every processed word leaves the result register as its hit says
    `WBPS_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, w_proc, r_out_valid == $past(w_res.hit))

endmodule

// ===== rtl/core/wbps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wbps_cfg_regs
// configuration registers and effective pattern length
// ----------------------------------------------------------------------------
module wbps_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output wbps_pkg::t_cfg                  o_cfg
);

    logic [wbps_pkg::LEN_W-1:0]      r_len;
    logic [wbps_pkg::CFG_DATA_W-1:0] r_pat_low;
    logic [wbps_pkg::CFG_DATA_W-1:0] r_pat_high;
    logic [wbps_pkg::MASK_W-1:0]     r_wild;
    wbps_pkg::t_cfg_reg              w_idx;

    assign w_idx = wbps_pkg::t_cfg_reg'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= wbps_pkg::LEN_W'(1);
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_wild     <= '0;
        end else if (i_cfg_we) begin
            case (w_idx)
                wbps_pkg::REG_PATTERN_LENGTH: r_len      <= i_cfg_data[wbps_pkg::LEN_W-1:0];
                wbps_pkg::REG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                wbps_pkg::REG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                wbps_pkg::REG_WILDCARD_MASK:  r_wild     <= i_cfg_data[wbps_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above the cap acts as the cap
    always_comb begin
        o_cfg.eff_len = r_len;
        if (r_len == '0) begin
            o_cfg.eff_len = wbps_pkg::LEN_W'(1);
        end else if (r_len > wbps_pkg::LEN_W'(wbps_pkg::PAT_CAP)) begin
            o_cfg.eff_len = wbps_pkg::LEN_W'(wbps_pkg::PAT_CAP);
        end
        o_cfg.pat  = {r_pat_high, r_pat_low};
        o_cfg.wild = r_wild;
    end

endmodule

// ===== rtl/core/wbps_matcher.sv =====
// ----------------------------------------------------------------------------
// wbps_matcher
// byte window, restart count and combinational wildcard compare
// ----------------------------------------------------------------------------
module wbps_matcher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  wbps_pkg::t_in_word i_word,
    input  wbps_pkg::t_cfg     i_cfg,
    output wbps_pkg::t_match   o_res
);

    logic [wbps_pkg::MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0] r_win;
    logic [wbps_pkg::MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0] n_win;
    logic [wbps_pkg::CNT_W-1:0]                            r_cnt;
    logic [wbps_pkg::CNT_W-1:0]                            n_cnt;
    logic [wbps_pkg::MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0] w_base;
    logic [wbps_pkg::CNT_W-1:0]                            w_cnt_base;
    logic [wbps_pkg::CNT_W-1:0]                            w_cnt_inc;
    logic                                                  w_all_ok;
    logic [wbps_pkg::LEN_W-1:0]                            w_pos;
    logic                                                  w_hit;

    always_comb begin
        // new region starts from an empty window
        w_base     = i_word.first ? '0 : r_win;
        w_cnt_base = i_word.first ? '0 : r_cnt;
        n_win[0]   = i_word.data;
        for (int k = 1; k < wbps_pkg::MAX_PATTERN; k++) begin
            n_win[k] = w_base[k-1];
        end
        w_cnt_inc = (w_cnt_base < wbps_pkg::CNT_W'(wbps_pkg::MAX_PATTERN))
                  ? w_cnt_base + wbps_pkg::CNT_W'(1) : w_cnt_base;

        // pattern byte i lines up with window slot len-1-i
        w_all_ok = 1'b1;
        w_pos    = '0;
        for (int i = 0; i < wbps_pkg::PAT_CAP; i++) begin
            w_pos = i_cfg.eff_len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(i);
            if (wbps_pkg::LEN_W'(i) < i_cfg.eff_len) begin
                if (!i_cfg.wild[i] &&
                    (n_win[w_pos[wbps_pkg::WIN_IDX_W-1:0]] != i_cfg.pat[i])) begin
                    w_all_ok = 1'b0;
                end
            end
        end

        w_hit = i_en && w_all_ok && (w_cnt_inc >= wbps_pkg::CNT_W'(i_cfg.eff_len));
        n_cnt = w_hit ? '0 : w_cnt_inc;

        o_res.hit  = w_hit;
        o_res.addr = i_word.addr
                   - wbps_pkg::ADDR_W'(i_cfg.eff_len - wbps_pkg::LEN_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_cnt <= '0;
        end else if (i_en) begin
            r_win <= n_win;
            r_cnt <= n_cnt;
        end
    end

endmodule
